FILE: design/itrw_pkg.sv
// Package for the I2C target register window: opcodes, result source codes,
// the access request struct, size constants and the fixed text ROM contents.
// No dependencies.
package itrw_pkg;

  // Default sizes of the register map
  localparam int REG_BYTES_DEF    = 64;
  localparam int RW_START_DEF     = 32;
  localparam int TXLEN_OFFSET_DEF = 40;
  localparam int TEXT_BYTES_DEF   = 288;
  localparam int TEXT_BASE_DEF    = 96;
  localparam int MAX_PAYLOAD_DEF  = 512;

  // Field and counter widths
  localparam int OP_W        = 3;
  localparam int HADDR_W     = 6;
  localparam int BYTE_W      = 8;
  localparam int PTR_W       = 8;
  localparam int COUNT_W     = 10;
  localparam int COUNT_LIMIT = 1023;
  localparam int SPAN_W      = 11;   // pointer plus count, no wrap
  localparam int STORE_AW    = 7;    // store address, enough for 96 bytes
  localparam int TEXT_IDX_W  = 9;    // text offset, enough for 512 bytes

  typedef enum logic [OP_W-1:0] {
    OP_BUS_WR   = 3'd0,
    OP_WR_STOP  = 3'd1,
    OP_BUS_RD   = 3'd2,
    OP_RD_STOP  = 3'd3,
    OP_HOST_WR  = 3'd4,
    OP_HOST_RD  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_STORE,
    SRC_TEXT
  } src_t;

  // One item's access to the store and the text ROM, plus stop pulses
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [STORE_AW-1:0]   addr;
    logic [BYTE_W-1:0]     wdata;
    src_t                  src;
    logic [TEXT_IDX_W-1:0] text_idx;
    logic                  st;
    logic                  rf;
  } itrw_req_t;

  // Fixed text, without its terminating nul
  localparam int TEXT_LEN = 287;
  localparam logic [8*TEXT_LEN-1:0] TEXT_ROM = {
    "This device complies with part 15 of the Furry Communications\n",
    "Commission Rules. Operation is subject to the following two\n",
    "conditions: (1) This device may not cause harmful awoos, and\n",
    "(2) this device must accept any hugs and scritches, including\n",
    "those that may cause undesired attention.\n"
  };

  // Text byte at an offset; zero past the end of the string
  function automatic logic [BYTE_W-1:0] text_byte(input logic [TEXT_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (int'(idx) < TEXT_LEN) begin
      b = TEXT_ROM[8*(TEXT_LEN-1-int'(idx)) +: 8];
    end
    return b;
  endfunction

endpackage

FILE: design/itrw_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module itrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/itrw_text_rom.sv
// Registered read port on the fixed text ROM.
// Depends on itrw_pkg for the text contents.
module itrw_text_rom
  import itrw_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [TEXT_IDX_W-1:0] idx,
  output logic [BYTE_W-1:0]     q
);

  logic [BYTE_W-1:0] q_r;

  // Look up the text byte and register it
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= text_byte(idx);
    end
  end

  assign q = q_r;

endmodule

FILE: design/itrw_ctrl.sv
// Byte engine of the register window: pointer, write and read counts,
// address decode into store / zero / text, and the write-stop pulses.
// Depends on itrw_pkg.
module itrw_ctrl
  import itrw_pkg::*;
#(
  parameter int REG_BYTES    = REG_BYTES_DEF,
  parameter int RW_START     = RW_START_DEF,
  parameter int TXLEN_OFFSET = TXLEN_OFFSET_DEF,
  parameter int TEXT_BYTES   = TEXT_BYTES_DEF,
  parameter int TEXT_BASE    = TEXT_BASE_DEF,
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [OP_W-1:0]    opcode,
  input  logic [HADDR_W-1:0] host_address,
  input  logic [BYTE_W-1:0]  data_byte,
  output itrw_req_t          req
);

  localparam int WCAP = (MAX_PAYLOAD + 1 > COUNT_LIMIT) ? COUNT_LIMIT : MAX_PAYLOAD + 1;
  localparam int RCAP = (MAX_PAYLOAD > COUNT_LIMIT) ? COUNT_LIMIT : MAX_PAYLOAD;

  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [COUNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [COUNT_W-1:0] rcnt_r, rcnt_nxt;

  logic [SPAN_W-1:0]  wr_addr, rd_addr, text_off;
  logic [COUNT_W-1:0] n_pay;
  logic [SPAN_W-1:0]  span_lo, span_end, span_hi;

  // Addresses of the next payload byte and the next read byte
  assign wr_addr  = SPAN_W'(ptr_r) + SPAN_W'(wcnt_r) - SPAN_W'(1);
  assign rd_addr  = SPAN_W'(ptr_r) + SPAN_W'(rcnt_r);
  assign text_off = rd_addr - SPAN_W'(TEXT_BASE);

  // Span of the finished write, clipped to the read-write window
  assign n_pay    = wcnt_r - COUNT_W'(1);
  assign span_lo  = (SPAN_W'(ptr_r) > SPAN_W'(RW_START)) ? SPAN_W'(ptr_r) : SPAN_W'(RW_START);
  assign span_end = SPAN_W'(ptr_r) + SPAN_W'(n_pay);
  assign span_hi  = (span_end > SPAN_W'(REG_BYTES)) ? SPAN_W'(REG_BYTES) : span_end;

  // Decode the item into a store access and the next pointer and counts
  always_comb begin
    req          = '0;
    req.src      = SRC_ZERO;
    req.wdata    = data_byte;
    ptr_nxt      = ptr_r;
    wcnt_nxt     = wcnt_r;
    rcnt_nxt     = rcnt_r;
    unique case (opcode)
      OP_BUS_WR: begin
        if (wcnt_r == '0) begin
          ptr_nxt = data_byte;
        end else if (int'(wcnt_r) < WCAP) begin
          if (wr_addr >= SPAN_W'(RW_START) && wr_addr < SPAN_W'(REG_BYTES)) begin
            req.we   = 1'b1;
            req.addr = STORE_AW'(wr_addr);
          end
        end
        if (int'(wcnt_r) < WCAP) begin
          wcnt_nxt = wcnt_r + COUNT_W'(1);
        end
      end
      OP_WR_STOP: begin
        if (wcnt_r == '0) begin
          ptr_nxt = '0;
        end else begin
          if (n_pay != '0 && span_lo < span_hi) begin
            if (SPAN_W'(ptr_r) <= SPAN_W'(TXLEN_OFFSET) && span_hi > SPAN_W'(TXLEN_OFFSET)) begin
              req.st = 1'b1;
            end else begin
              req.rf = 1'b1;
            end
          end
          ptr_nxt = span_end[PTR_W-1:0];
        end
        wcnt_nxt = '0;
      end
      OP_BUS_RD: begin
        if (int'(rcnt_r) < RCAP) begin
          if (rd_addr < SPAN_W'(REG_BYTES)) begin
            req.re   = 1'b1;
            req.addr = STORE_AW'(rd_addr);
            req.src  = SRC_STORE;
          end else if (rd_addr >= SPAN_W'(TEXT_BASE) && text_off < SPAN_W'(TEXT_BYTES)) begin
            req.src      = SRC_TEXT;
            req.text_idx = TEXT_IDX_W'(text_off);
          end
          rcnt_nxt = rcnt_r + COUNT_W'(1);
        end
      end
      OP_RD_STOP: begin
        ptr_nxt  = ptr_r + rcnt_r[PTR_W-1:0];
        rcnt_nxt = '0;
      end
      OP_HOST_WR: begin
        if (int'(host_address) < REG_BYTES) begin
          req.we   = 1'b1;
          req.addr = STORE_AW'(host_address);
        end
      end
      OP_HOST_RD: begin
        if (int'(host_address) < REG_BYTES) begin
          req.re   = 1'b1;
          req.addr = STORE_AW'(host_address);
          req.src  = SRC_STORE;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit pointer and counts on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      wcnt_r <= '0;
      rcnt_r <= '0;
    end else if (acc) begin
      ptr_r  <= ptr_nxt;
      wcnt_r <= wcnt_nxt;
      rcnt_r <= rcnt_nxt;
    end
  end

endmodule

FILE: design/i2c_target_register_window.sv
// Top level of the I2C target register window: byte engine, register store
// RAM with per-byte valid bits, text ROM and the result registers.
// Depends on itrw_pkg, itrw_ctrl, itrw_ram and itrw_text_rom.
//
// Usage: the bus side of an I2C target presents one byte event per item on
// in_opcode / in_host_address / in_data_byte and raises start; the item is
// taken at a clock edge where start is high and busy is low. The same port
// carries host reads and writes of the register store.
// Each item gives exactly one result, shown on out_read_data,
// out_start_transmit and out_beacon_refresh for one cycle while out_strobe
// is high, in the cycle right after the item is taken.
// A new item may be taken every cycle: the store RAM is read or written once
// per item at its accept edge, and its registered read feeds the result.
// The receiver cannot stall; each result is gone after its strobe cycle.
// Reset (rst_n low, synchronous) clears the pointer, both byte counts and
// the store's valid bits, so every store byte reads zero until written; no
// clearing pass runs. busy stays high for the reset cycles and the first
// edge after, then low.
module i2c_target_register_window
  import itrw_pkg::*;
#(
  parameter int REG_BYTES    = REG_BYTES_DEF,
  parameter int RW_START     = RW_START_DEF,
  parameter int TXLEN_OFFSET = TXLEN_OFFSET_DEF,
  parameter int TEXT_BYTES   = TEXT_BYTES_DEF,
  parameter int TEXT_BASE    = TEXT_BASE_DEF,
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [HADDR_W-1:0] in_host_address,
  input  logic [BYTE_W-1:0]  in_data_byte,
  output logic               out_strobe,
  output logic [BYTE_W-1:0]  out_read_data,
  output logic               out_start_transmit,
  output logic               out_beacon_refresh
);

  localparam int AW = $clog2(REG_BYTES);

  logic              busy_r;
  logic              acc;
  itrw_req_t         req;
  logic [BYTE_W-1:0] ram_q, text_q;
  logic              vld_r [REG_BYTES];
  logic              vld_q_r;
  logic              strobe_r;
  src_t              src_r;
  logic              st_r, rf_r;

  assign acc  = start && !busy_r;
  assign busy = busy_r;

  // Hold off items through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  itrw_ctrl #(
    .REG_BYTES    (REG_BYTES),
    .RW_START     (RW_START),
    .TXLEN_OFFSET (TXLEN_OFFSET),
    .TEXT_BYTES   (TEXT_BYTES),
    .TEXT_BASE    (TEXT_BASE),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .opcode       (in_opcode),
    .host_address (in_host_address),
    .data_byte    (in_data_byte),
    .req          (req)
  );

  itrw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (REG_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (acc && req.we),
    .re    (acc && req.re),
    .addr  (req.addr[AW-1:0]),
    .wdata (req.wdata),
    .rdata (ram_q)
  );

  itrw_text_rom u_text (
    .clk (clk),
    .en  (acc && req.src == SRC_TEXT),
    .idx (req.text_idx),
    .q   (text_q)
  );

  // Mark written store bytes; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_BYTES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (acc && req.we) begin
      vld_r[req.addr[AW-1:0]] <= 1'b1;
    end
  end

  // Sample the valid bit alongside the RAM read
  always_ff @(posedge clk) begin
    if (acc && req.re) begin
      vld_q_r <= vld_r[req.addr[AW-1:0]];
    end
  end

  // Result registers: one result per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      src_r    <= SRC_ZERO;
      st_r     <= 1'b0;
      rf_r     <= 1'b0;
    end else begin
      strobe_r <= acc;
      src_r    <= acc ? req.src : SRC_ZERO;
      st_r     <= acc && req.st;
      rf_r     <= acc && req.rf;
    end
  end

  // Select the returned byte
  always_comb begin
    case (src_r)
      SRC_STORE: out_read_data = vld_q_r ? ram_q : '0;
      SRC_TEXT:  out_read_data = text_q;
      default:   out_read_data = '0;
    endcase
  end

  assign out_strobe         = strobe_r;
  assign out_start_transmit = st_r;
  assign out_beacon_refresh = rf_r;

  // Every accepted item yields a strobe in the next cycle
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_strobe)
    else $error("accepted item produced no result strobe");

  // No strobe without an accepted item
  a_no_stray_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc))
    else $error("result strobe without an accepted item");

  // Stop pulses are exclusive and come only with a strobe
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_start_transmit || out_beacon_refresh) |->
      (out_strobe && !(out_start_transmit && out_beacon_refresh)))
    else $error("bad write-stop pulse");

  // Store accesses stay inside the store
  a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (req.we || req.re)) |-> (int'(req.addr) < REG_BYTES))
    else $error("store access out of range");

endmodule

FILE: tb/sv/tb_i2c_target_register_window.sv
// Testbench for i2c_target_register_window: drives bus and host byte events,
// predicts every result with a shadow of the register map and checks each one.
// Depends on itrw_pkg and the i2c_target_register_window RTL.
module tb_i2c_target_register_window;
  import itrw_pkg::*;

  // Register map sizes, passed to the block so both sides agree
  localparam int REG_BYTES     = 64;
  localparam int RW_START      = 32;
  localparam int TXLEN_OFFSET  = 40;
  localparam int TEXT_BYTES    = 288;
  localparam int TEXT_BASE     = 96;
  localparam int MAX_PAYLOAD   = 512;
  localparam int COUNT_CEILING = 1023;
  localparam int WRITE_CAP     = (MAX_PAYLOAD + 1 > COUNT_CEILING) ? COUNT_CEILING
                                                                  : MAX_PAYLOAD + 1;
  localparam int READ_CAP      = (MAX_PAYLOAD > COUNT_CEILING) ? COUNT_CEILING : MAX_PAYLOAD;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  // Opcodes the block does not define
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              start_transmit;
    logic              beacon_refresh;
  } window_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    in_opcode;
  logic [HADDR_W-1:0] in_host_address;
  logic [BYTE_W-1:0]  in_data_byte;
  logic               out_strobe;
  logic [BYTE_W-1:0]  out_read_data;
  logic               out_start_transmit;
  logic               out_beacon_refresh;

  // Shadow of the register map
  logic [BYTE_W-1:0] shadow_store [REG_BYTES];
  logic [PTR_W-1:0]  addr_ptr;
  int                payload_seen;
  int                reads_seen;

  window_result_t due_results[$];
  int             fail_count = 0;
  int             sent_items = 0;
  int             sender_idle_pct = 0;
  int             quiet_cycles = 0;

  string notice_text = {
    "This device complies with part 15 of the Furry Communications\n",
    "Commission Rules. Operation is subject to the following two\n",
    "conditions: (1) This device may not cause harmful awoos, and\n",
    "(2) this device must accept any hugs and scritches, including\n",
    "those that may cause undesired attention.\n"
  };

  i2c_target_register_window #(
    .REG_BYTES    (REG_BYTES),
    .RW_START     (RW_START),
    .TXLEN_OFFSET (TXLEN_OFFSET),
    .TEXT_BYTES   (TEXT_BYTES),
    .TEXT_BASE    (TEXT_BASE),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_host_address    (in_host_address),
    .in_data_byte       (in_data_byte),
    .out_strobe         (out_strobe),
    .out_read_data      (out_read_data),
    .out_start_transmit (out_start_transmit),
    .out_beacon_refresh (out_beacon_refresh)
  );

  always #4 clk = ~clk;

  // Byte seen by a bus read at a linear address: store, zero gap, text, zero
  function automatic logic [BYTE_W-1:0] bus_byte(input int addr);
    int t;
    if (addr < REG_BYTES) begin
      return shadow_store[addr];
    end
    if (addr < TEXT_BASE) begin
      return '0;
    end
    t = addr - TEXT_BASE;
    if (t < TEXT_BYTES && t < notice_text.len()) begin
      return notice_text[t];
    end
    return '0;
  endfunction

  // Apply one byte event to the shadow map and return the result it causes
  function automatic window_result_t step_window(input logic [OP_W-1:0] op,
                                                 input logic [HADDR_W-1:0] haddr,
                                                 input logic [BYTE_W-1:0] dbyte);
    window_result_t res;
    int p, n, lo, hi, a;
    res = '0;
    case (op)
      OP_BUS_WR: begin
        if (payload_seen == 0) begin
          addr_ptr = dbyte;
        end else if (payload_seen < WRITE_CAP) begin
          a = int'(addr_ptr) + payload_seen - 1;
          if (a >= RW_START && a < REG_BYTES) begin
            shadow_store[a] = dbyte;
          end
        end
        if (payload_seen < WRITE_CAP) begin
          payload_seen++;
        end
      end
      OP_WR_STOP: begin
        if (payload_seen == 0) begin
          addr_ptr = '0;
        end else begin
          n  = payload_seen - 1;
          p  = int'(addr_ptr);
          lo = (p > RW_START) ? p : RW_START;
          hi = (p + n > REG_BYTES) ? REG_BYTES : p + n;
          // Pulse only if some payload landed in the read-write window
          if (n > 0 && lo < hi) begin
            if (p <= TXLEN_OFFSET && hi > TXLEN_OFFSET) begin
              res.start_transmit = 1'b1;
            end else begin
              res.beacon_refresh = 1'b1;
            end
          end
          addr_ptr = PTR_W'((p + n) % 256);
        end
        payload_seen = 0;
      end
      OP_BUS_RD: begin
        if (reads_seen < READ_CAP) begin
          res.read_data = bus_byte(int'(addr_ptr) + reads_seen);
          reads_seen++;
        end
      end
      OP_RD_STOP: begin
        addr_ptr   = PTR_W'((int'(addr_ptr) + reads_seen) % 256);
        reads_seen = 0;
      end
      OP_HOST_WR: begin
        if (int'(haddr) < REG_BYTES) begin
          shadow_store[haddr] = dbyte;
        end
      end
      OP_HOST_RD: begin
        if (int'(haddr) < REG_BYTES) begin
          res.read_data = shadow_store[haddr];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Check each strobed result against the oldest prediction, then predict
  always @(posedge clk) begin : check_results
    window_result_t want;
    window_result_t got;
    if (rst_n) begin
      if (out_strobe) begin
        got = {out_read_data, out_start_transmit, out_beacon_refresh};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result rd=%02h st=%0b rf=%0b", $time,
                   got.read_data, got.start_transmit, got.beacon_refresh);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected rd=%02h st=%0b rf=%0b, got rd=%02h st=%0b rf=%0b",
                     $time, want.read_data, want.start_transmit, want.beacon_refresh,
                     got.read_data, got.start_transmit, got.beacon_refresh);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        due_results.push_back(step_window(in_opcode, in_host_address, in_data_byte));
      end
    end
  end

  // Abort if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Send one item; called and returns at a falling edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [HADDR_W-1:0] haddr,
                           input logic [BYTE_W-1:0] dbyte);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_host_address <= haddr;
    in_data_byte    <= dbyte;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (op <= OP_HOST_RD) begin
      sent_items++;
    end
  endtask

  // Random field values at their port widths
  function automatic logic [HADDR_W-1:0] rand_addr();
    return HADDR_W'($urandom_range(63));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_pointer();
    if ($urandom_range(3) == 0) begin
      return rand_byte();
    end
    return BYTE_W'($urandom_range(24, 66));
  endfunction

  // Host side: writes to the lowest and highest address, then reads both back
  task automatic test_host_access();
    send_item(OP_HOST_WR, 6'd0, 8'hFF);
    send_item(OP_HOST_WR, 6'd63, 8'hA5);
    send_item(OP_HOST_RD, 6'd0, 8'h00);
    send_item(OP_HOST_RD, 6'd63, 8'h00);
  endtask

  // Bus writes: transmit length covered, other read-write bytes, read-only only,
  // empty write, address only
  task automatic test_bus_writes();
    send_item(OP_BUS_WR, 6'd0, 8'd38);
    send_item(OP_BUS_WR, 6'd0, 8'h11);
    send_item(OP_BUS_WR, 6'd0, 8'h22);
    send_item(OP_BUS_WR, 6'd0, 8'h33);
    send_item(OP_WR_STOP, 6'd0, 8'h00);
    send_item(OP_BUS_WR, 6'd0, 8'd60);
    send_item(OP_BUS_WR, 6'd0, 8'h77);
    send_item(OP_WR_STOP, 6'd0, 8'h00);
    send_item(OP_BUS_WR, 6'd0, 8'd5);
    send_item(OP_BUS_WR, 6'd0, 8'h99);
    send_item(OP_WR_STOP, 6'd0, 8'h00);
    send_item(OP_WR_STOP, 6'd0, 8'h00);
    send_item(OP_BUS_WR, 6'd0, 8'd94);
    send_item(OP_WR_STOP, 6'd0, 8'h00);
  endtask

  // Bus reads across the zero gap into the text
  task automatic test_bus_reads();
    repeat (3) send_item(OP_BUS_RD, 6'd0, 8'h00);
    send_item(OP_RD_STOP, 6'd0, 8'h00);
  endtask

  task automatic test_spare_opcodes();
    send_item(OP_SPARE_LO, 6'h3F, 8'hFF);
    send_item(OP_SPARE_HI, 6'h2A, 8'h55);
  endtask

  // Payload and read overflow: run both transfers past the limit
  task automatic test_overflow();
    send_item(OP_BUS_WR, 6'd0, 8'd32);
    repeat (MAX_PAYLOAD + 3) send_item(OP_BUS_WR, rand_addr(), rand_byte());
    send_item(OP_WR_STOP, 6'd0, 8'h00);
    repeat (MAX_PAYLOAD + 3) send_item(OP_BUS_RD, rand_addr(), rand_byte());
    send_item(OP_RD_STOP, 6'd0, 8'h00);
  endtask

  // Mostly complete transfers with random content, some host traffic and noise
  task automatic run_random_transaction();
    int kind, len;
    kind = $urandom_range(99);
    len  = $urandom_range(0, 10);
    if (kind < 40) begin
      send_item(OP_BUS_WR, rand_addr(), pick_pointer());
      repeat (len) send_item(OP_BUS_WR, rand_addr(), rand_byte());
      send_item(OP_WR_STOP, rand_addr(), rand_byte());
    end else if (kind < 70) begin
      if ($urandom_range(1) == 1) begin
        send_item(OP_BUS_WR, rand_addr(), rand_byte());
        send_item(OP_WR_STOP, rand_addr(), rand_byte());
      end
      repeat (len) send_item(OP_BUS_RD, rand_addr(), rand_byte());
      send_item(OP_RD_STOP, rand_addr(), rand_byte());
    end else if (kind < 80) begin
      send_item(OP_HOST_WR, rand_addr(), rand_byte());
    end else if (kind < 88) begin
      send_item(OP_HOST_RD, rand_addr(), rand_byte());
    end else begin
      send_item(OP_W'($urandom_range(7)), rand_addr(), rand_byte());
    end
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    target = sent_items + count;
    while (sent_items < target) run_random_transaction();
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = OP_BUS_WR;
    in_host_address = '0;
    in_data_byte    = '0;
    addr_ptr        = '0;
    payload_seen    = 0;
    reads_seen      = 0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 7;
    test_host_access();
    test_bus_writes();
    test_bus_reads();
    test_spare_opcodes();
    test_random_traffic(50);
    sender_idle_pct = 48;
    test_random_traffic(50);
    sender_idle_pct = 0;
    test_random_traffic(50);
    test_overflow();
    start <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: i2c_target_register_window.f
design/itrw_pkg.sv
design/itrw_ram.sv
design/itrw_text_rom.sv
design/itrw_ctrl.sv
design/i2c_target_register_window.sv
tb/sv/tb_i2c_target_register_window.sv
